// ----- hw/rtl/gbts_pkg.sv -----
// Shared types, codes and constants of the gap buffer text store.
`default_nettype none
package gbts_pkg;

    localparam int          CAPACITY_DEF = 4096;
    localparam int          FW           = 13;     // width of position/length fields
    localparam logic [7:0]  NEWLINE      = 8'h0A;

    typedef enum logic [3:0] {
        OP_INSERT = 4'd0,
        OP_ERASE  = 4'd1,
        OP_READ   = 4'd2,
        OP_CLEAR  = 4'd3,
        OP_LINES  = 4'd4,
        OP_LSTART = 4'd5,
        OP_LEND   = 4'd6,
        OP_LINEOF = 4'd7,
        OP_COLUMN = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOLINE = 2'd3
    } status_t;

    // what an accepted command needs after decode
    typedef enum logic [1:0] {
        K_COMMIT = 2'd0,
        K_MOVE   = 2'd1,
        K_READ   = 2'd2,
        K_SCAN   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_MOVE, S_COMMIT, S_RD, S_RD_WAIT, S_SCAN, S_RESULT
    } state_t;

    typedef struct packed {
        logic [3:0]    operation;
        logic [FW-1:0] position;
        logic [7:0]    char_in;
        logic [FW-1:0] erase_length;
        logic [FW-1:0] line_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [7:0]    char_out;
        logic [FW-1:0] text_length;
        logic [FW-1:0] answer;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic move_en;
        logic commit;
        logic rd_issue;
        logic rd_capture;
        logic scan_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  move_done;
        logic  scan_done;
        logic  out_busy;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/gbts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];    // read-first on same-address collision
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gbts_ctrl.sv -----
// Controller state machine of the gap buffer text store.
`default_nettype none
module gbts_ctrl
    import gbts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire dp_sts_t   sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd_ready  = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                unique case (sts.kind)
                    K_COMMIT: state_next = S_COMMIT;
                    K_MOVE:   state_next = S_MOVE;
                    K_READ:   state_next = S_RD;
                    K_SCAN:   state_next = S_SCAN;
                    default:  state_next = S_COMMIT;
                endcase
            end
            S_MOVE:
            begin
                cmd.move_en = 1'b1;
                if (sts.move_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gbts_datapath.sv -----
// Datapath of the gap buffer text store: gap pointers, store, scan and result.
`default_nettype none
module gbts_datapath
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  cmd_data,
    input  wire ctrl_cmd_t cmd,
    output dp_sts_t        sts,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output out_item_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > FW) ? LW : FW;

    // gap pointers
    logic [LW-1:0] gb_reg, gb_next, gf_reg, gf_next;
    // latched command
    logic [3:0]    op_reg;
    logic [FW-1:0] pos_reg, elen_reg, lidx_reg;
    logic [7:0]    ch_reg;
    // decode results
    logic [1:0]    status_reg;
    logic [LW-1:0] target_reg, erase_n_reg, limit_reg;
    // scan state
    logic [LW-1:0] idx_reg, ridx_reg, cnt_reg, start_reg, end_reg;
    logic          rvalid_reg, found_reg, done_reg;
    logic [7:0]    char_reg;
    // pending move write
    logic          pend_valid_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          rsp_valid_reg;
    out_item_t     rsp_reg;

    logic [LW-1:0] len, gap;
    logic [CW-1:0] len_c, pos_c, elen_c, lidx_c, rem_c;
    kind_t         kind;
    logic [1:0]    st_dec;
    logic [LW-1:0] erase_n, limit;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic          step, left, scan_issue, nl_hit;

    assign len    = LW'(gb_reg + (LW'(CAPACITY) - gf_reg));
    assign gap    = gf_reg - gb_reg;
    assign len_c  = CW'(len);
    assign pos_c  = CW'(pos_reg);
    assign elen_c = CW'(elen_reg);
    assign lidx_c = CW'(lidx_reg);
    assign rem_c  = len_c - pos_c;

    function automatic logic [AW-1:0] phys(input logic [LW-1:0] i,
                                           input logic [LW-1:0] g_begin,
                                           input logic [LW-1:0] g_size);
        logic [LW-1:0] a;
        a = (i < g_begin) ? i : LW'(i + g_size);
        return AW'(a);
    endfunction

    // decode of the latched command against the current text
    always_comb
    begin
        kind    = K_COMMIT;
        st_dec  = ST_OK;
        erase_n = '0;
        limit   = len;
        case (op_reg)
            OP_INSERT:
            begin
                if (pos_c > len_c)
                begin
                    st_dec = ST_RANGE;
                end
                else if (len_c >= CW'(CAPACITY))
                begin
                    st_dec = ST_FULL;
                end
                else
                begin
                    kind = K_MOVE;
                end
            end
            OP_ERASE:
            begin
                if (pos_c >= len_c)
                begin
                    st_dec = ST_RANGE;
                end
                else if (elen_c != '0)
                begin
                    kind    = K_MOVE;
                    erase_n = (elen_c > rem_c) ? LW'(rem_c) : LW'(elen_c);
                end
            end
            OP_READ:
            begin
                if (pos_c >= len_c)
                begin
                    st_dec = ST_RANGE;
                end
                else
                begin
                    kind = K_READ;
                end
            end
            OP_CLEAR: kind = K_COMMIT;
            OP_LINES, OP_LEND: kind = K_SCAN;
            OP_LSTART: kind = (lidx_reg == '0) ? K_COMMIT : K_SCAN;
            OP_LINEOF, OP_COLUMN:
            begin
                kind  = K_SCAN;
                limit = (pos_c < len_c) ? LW'(pos_c) : len;
            end
            default: st_dec = ST_RANGE;
        endcase
    end

    // gap move: one byte per cycle, the write of each byte follows its read in the next cycle
    assign step = cmd.move_en && (gb_reg != target_reg);
    assign left = (target_reg < gb_reg);

    assign scan_issue = cmd.scan_en && !done_reg && (idx_reg != limit_reg);
    assign nl_hit     = rvalid_reg && !done_reg && (rdata == NEWLINE);

    always_comb
    begin
        priority if (step)
        begin
            raddr = left ? AW'(gb_reg - 1'b1) : AW'(gf_reg);
        end
        else if (cmd.rd_issue)
        begin
            raddr = phys(LW'(pos_reg), gb_reg, gap);
        end
        else
        begin
            raddr = phys(idx_reg, gb_reg, gap);
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = pend_addr_reg;
        wdata = rdata;
        if (pend_valid_reg)
        begin
            we = 1'b1;
        end
        else if (cmd.commit && op_reg == OP_INSERT && status_reg == ST_OK)
        begin
            we    = 1'b1;
            waddr = AW'(gb_reg);
            wdata = ch_reg;
        end
    end

    gbts_ram #(
        .WIDTH(8),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        gb_next = gb_reg;
        gf_next = gf_reg;
        if (step)
        begin
            gb_next = left ? gb_reg - 1'b1 : gb_reg + 1'b1;
            gf_next = left ? gf_reg - 1'b1 : gf_reg + 1'b1;
        end
        else if (cmd.commit && status_reg == ST_OK)
        begin
            case (op_reg)
                OP_INSERT: gb_next = gb_reg + 1'b1;
                OP_ERASE:  gf_next = gf_reg + erase_n_reg;
                OP_CLEAR:
                begin
                    gb_next = '0;
                    gf_next = LW'(CAPACITY);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_reg         <= '0;
            gf_reg         <= LW'(CAPACITY);
            pend_valid_reg <= 1'b0;
            rvalid_reg     <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            gb_reg         <= gb_next;
            gf_reg         <= gf_next;
            pend_valid_reg <= step;
            rvalid_reg     <= scan_issue;
            if (cmd.decide)
            begin
                done_reg  <= 1'b0;
                found_reg <= (lidx_reg == '0);
            end
            else if (nl_hit)
            begin
                if (op_reg == OP_LEND && found_reg)
                begin
                    done_reg <= 1'b1;
                end
                else if ((op_reg == OP_LSTART || op_reg == OP_LEND)
                         && (CW'(cnt_reg) + 1'b1 == lidx_c))
                begin
                    found_reg <= 1'b1;
                    done_reg  <= (op_reg == OP_LSTART);
                end
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= cmd_data.operation;
            pos_reg  <= cmd_data.position;
            ch_reg   <= cmd_data.char_in;
            elen_reg <= cmd_data.erase_length;
            lidx_reg <= cmd_data.line_index;
        end
        if (cmd.decide)
        begin
            status_reg  <= st_dec;
            target_reg  <= LW'(pos_c);
            erase_n_reg <= erase_n;
            limit_reg   <= limit;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
        end
        else
        begin
            if (scan_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (nl_hit)
            begin
                case (op_reg)
                    OP_LSTART, OP_LEND:
                    begin
                        if (found_reg)
                        begin
                            end_reg <= ridx_reg;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            if (CW'(cnt_reg) + 1'b1 == lidx_c)
                            begin
                                start_reg <= ridx_reg + 1'b1;
                            end
                        end
                    end
                    OP_COLUMN: start_reg <= ridx_reg + 1'b1;
                    default:   cnt_reg   <= cnt_reg + 1'b1;
                endcase
            end
        end
        if (step)
        begin
            pend_addr_reg <= left ? AW'(gf_reg - 1'b1) : AW'(gb_reg);
        end
        ridx_reg <= idx_reg;
        if (cmd.rd_capture)
        begin
            char_reg <= rdata;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.char_out    <= '0;
            rsp_reg.text_length <= FW'(len_c);
            rsp_reg.answer      <= '0;
            case (op_reg)
                OP_READ:
                begin
                    if (status_reg == ST_OK)
                    begin
                        rsp_reg.char_out <= char_reg;
                    end
                end
                OP_LINES:  rsp_reg.answer <= FW'(CW'(cnt_reg) + 1'b1);
                OP_LSTART:
                begin
                    if (found_reg)
                    begin
                        rsp_reg.answer <= FW'(CW'(start_reg));
                    end
                    else
                    begin
                        rsp_reg.status <= ST_NOLINE;
                    end
                end
                OP_LEND:
                begin
                    if (found_reg)
                    begin
                        rsp_reg.answer <= done_reg ? FW'(CW'(end_reg)) : FW'(len_c);
                    end
                    else
                    begin
                        rsp_reg.status <= ST_NOLINE;
                    end
                end
                OP_LINEOF: rsp_reg.answer <= FW'(CW'(cnt_reg));
                OP_COLUMN: rsp_reg.answer <= FW'(pos_c - CW'(start_reg));
                default: ;
            endcase
        end
    end

    assign sts.kind      = kind;
    assign sts.move_done = (gb_reg == target_reg) && !pend_valid_reg;
    assign sts.scan_done = done_reg || ((idx_reg == limit_reg) && !rvalid_reg);
    assign sts.out_busy  = rsp_valid_reg && !rsp_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/gap_buffer_text_store.sv -----
// Top level of the gap buffer text store.
// One command is taken per transfer on the cmd channel and answered by
// exactly one transfer on the rsp channel, in order. Commands are worked
// one at a time; cmd_ready is high only while the controller is idle, and
// a finished response sits in its own register, so the next command may be
// taken while the previous response still waits for rsp_ready. Timing is
// set by the single read port of the byte store: an accepted insert, or an
// erase of nonzero length, moves the gap to the position one byte per cycle;
// the line queries walk the text one byte per cycle, up to CAPACITY bytes.
// The store is never cleared; gap pointers reset to an empty text.
`default_nettype none
module gap_buffer_text_store
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire in_item_t  cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output out_item_t      rsp
);

    ctrl_cmd_t ctl;    // controller commands to the datapath
    dp_sts_t   sts;    // datapath status back to the controller

    gbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .sts      (sts),
        .cmd      (ctl)
    );

    gbts_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_data (cmd),
        .cmd      (ctl),
        .sts      (sts),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/gbts_checker.sv -----
// Port-level checker of the gap buffer text store and its bind.
`default_nettype none
module gbts_checker
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire in_item_t  cmd,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire out_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.text_length == FW'(CAPACITY))
        else $error("store full reported below capacity");

    a_noline_ans: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_NOLINE |-> rsp.answer == '0)
        else $error("missing line with nonzero answer");

    a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.char_out == '0)
        else $error("byte returned on failed command");

endmodule

bind gap_buffer_text_store gbts_checker #(.CAPACITY(CAPACITY)) u_chk (.*);
`default_nettype wire

// ----- tb/tb_gap_buffer_text_store.sv -----
// Testbench for the gap buffer text store: random and directed commands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_gap_buffer_text_store;
    import gbts_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int CYC_LIMIT = 3_000_000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_item_t  cmd;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;

    gap_buffer_text_store DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Predictor state: the text itself, kept flat (gap position does not
    // change what the block answers).
    logic [7:0] text_q[$];

    in_item_t  pending_cmds[$];     // waiting for the driver
    out_item_t expected_rsps[$];    // predicted, not yet seen
    int        errors;
    int        sent;
    int        cycles;
    bit        hold_off;            // sender pauses until drained
    bit        stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int exp);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, exp, $realtime);
        errors++;
    endtask

    // Start position of a zero-based line; returns 0 if absent.
    function automatic bit find_line(input int line, output int start);
        int seen;
        seen  = 0;
        start = 0;
        if (line == 0)
            return 1'b1;
        foreach (text_q[i])
        begin
            if (text_q[i] == NEWLINE)
            begin
                seen++;
                if (seen == line)
                begin
                    start = i + 1;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int lines_before(input int pos);
        int n;
        n = 0;
        for (int i = 0; i < pos && i < text_q.size(); i++)
            if (text_q[i] == NEWLINE)
                n++;
        return n;
    endfunction

    // Applies one accepted command to the text and returns its response.
    function automatic out_item_t apply_command(input in_item_t c);
        out_item_t r;
        int len, pos, cnt, s;
        r   = '0;
        len = text_q.size();
        pos = c.position;
        case (c.operation)
            OP_INSERT:
                if (pos > len)
                    r.status = ST_RANGE;
                else if (len >= CAP)
                    r.status = ST_FULL;
                else
                    text_q.insert(pos, c.char_in);
            OP_ERASE:
                if (pos >= len)
                    r.status = ST_RANGE;
                else
                begin
                    cnt = c.erase_length;
                    if (cnt > len - pos)
                        cnt = len - pos;
                    repeat (cnt) text_q.delete(pos);
                end
            OP_READ:
                if (pos >= len)
                    r.status = ST_RANGE;
                else
                    r.char_out = text_q[pos];
            OP_CLEAR:
                text_q.delete();
            OP_LINES:
                r.answer = 13'(lines_before(len) + 1);
            OP_LSTART:
                if (find_line(c.line_index, s))
                    r.answer = 13'(s);
                else
                    r.status = ST_NOLINE;
            OP_LEND:
                if (find_line(c.line_index, s))
                begin
                    cnt = len;
                    for (int i = s; i < len; i++)
                        if (text_q[i] == NEWLINE)
                        begin
                            cnt = i;
                            break;
                        end
                    r.answer = 13'(cnt);
                end
                else
                    r.status = ST_NOLINE;
            OP_LINEOF:
                r.answer = 13'(lines_before(pos));
            OP_COLUMN:
            begin
                void'(find_line(lines_before(pos), s));
                r.answer = 13'(pos - s);
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.text_length = 13'(text_q.size());
        return r;
    endfunction

    function automatic in_item_t make_cmd(input op_t op, input int pos, input int ch,
                                          input int elen, input int lidx);
        in_item_t c;
        c.operation    = op;
        c.position     = 13'(pos);
        c.char_in      = 8'(ch);
        c.erase_length = 13'(elen);
        c.line_index   = 13'(lidx);
        return c;
    endfunction

    // Random noise on char_in and erase_length, which most operations ignore, so every bit toggles.
    function automatic in_item_t rand_cmd(input logic [3:0] op, input int pos, input int lidx);
        in_item_t c;
        c.operation    = op;
        c.position     = 13'(pos);
        c.char_in      = 8'($urandom);
        c.erase_length = 13'($urandom_range(0, 8));
        c.line_index   = 13'(lidx);
        if ($urandom_range(0, 15) == 0)
            c.erase_length = 13'($urandom);
        return c;
    endfunction

    // Driver: bursts of valid cycles separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                expected_rsps.push_back(apply_command(cmd));
                sent++;
            end
            if (cmd_valid && !cmd_ready)
                ; // hold the transfer
            else if (gap_left > 0 || hold_off || pending_cmds.size() == 0)
            begin
                cmd_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                cmd_valid <= 1'b1;
                cmd       <= pending_cmds.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor and response-side stall pattern.
    logic [7:0] stall_lfsr;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_lfsr <= 8'h5B;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("unexpected response (t=%0t)", $realtime);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status)
                        report("status", rsp.status, e.status);
                    if (rsp.char_out !== e.char_out)
                        report("char_out", rsp.char_out, e.char_out);
                    if (rsp.text_length !== e.text_length)
                        report("text_length", rsp.text_length, e.text_length);
                    if (rsp.answer !== e.answer)
                        report("answer", rsp.answer, e.answer);
                end
            end
            stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5]
                           ^ stall_lfsr[4] ^ stall_lfsr[3]};
            // Long clear stretches at the top of the pattern, stalls elsewhere.
            rsp_ready <= stall_lfsr[7] | (stall_lfsr[2:0] != 3'd0);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus: directed part, then random traffic mostly on a small text.
    initial
    begin
        int model_len;
        int r;
        int pos;
        logic [3:0] op;
        errors     = 0;
        sent       = 0;
        cycles     = 0;
        hold_off   = 1'b0;
        stim_done  = 1'b0;
        rst_n      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-text corners, every op, extremes of the fields.
        pending_cmds.push_back(make_cmd(OP_READ,   0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ERASE,  0, 0, 5, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 1, 8'hFF, 0, 0));      // beyond text
        pending_cmds.push_back(make_cmd(OP_INSERT, 0, 8'h41, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 1, NEWLINE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 2, 8'hFF, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 0, 8'h00, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LINES,  0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LSTART, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_LEND,   0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LEND,   0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_LSTART, 0, 0, 0, 13'h1FFF));  // line not found
        pending_cmds.push_back(make_cmd(OP_LEND,   0, 0, 0, 2));
        pending_cmds.push_back(make_cmd(OP_LINEOF, 13'h1FFF, 0, 0, 0));  // beyond text
        pending_cmds.push_back(make_cmd(OP_COLUMN, 3, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_COLUMN, 13'h1FFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ,   2, 0, 13'h1FFF, 0));
        pending_cmds.push_back(make_cmd(OP_READ,   4, 0, 0, 0));
        pending_cmds.push_back(op_t'(4'd9) == OP_INSERT ? '0 : make_cmd(OP_READ, 0, 0, 0, 0));
        pending_cmds.push_back(rand_cmd(4'd15, 13'h1FFF, 13'h1FFF));     // unknown op
        pending_cmds.push_back(rand_cmd(4'd9, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ERASE,  1, 0, 0, 0));          // zero length
        pending_cmds.push_back(make_cmd(OP_ERASE,  1, 0, 13'h1FFF, 0));   // overlong
        pending_cmds.push_back(make_cmd(OP_CLEAR,  0, 0, 0, 0));
        model_len = 2;

        // Drain once with the sender held off.
        wait (pending_cmds.size() == 0 && !cmd_valid);
        hold_off = 1'b1;
        wait (expected_rsps.size() == 0 && !cmd_valid);
        hold_off = 1'b0;

        // Random: inserts dominate so the text grows with many newlines.
        model_len = 0;
        for (int n = 0; n < 116; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                pos = (r < 3) ? model_len + 1 : $urandom_range(0, model_len);
                pending_cmds.push_back(rand_cmd(OP_INSERT, pos, 0));
                if ($urandom_range(0, 3) == 0)
                    pending_cmds[$].char_in = NEWLINE;
                if (pos <= model_len)
                    model_len++;
            end
            else
            begin
                if (r < 48)      op = OP_ERASE;
                else if (r < 60) op = OP_READ;
                else if (r < 62) op = OP_CLEAR;
                else if (r < 98) op = 4'($urandom_range(OP_LINES, OP_COLUMN));
                else             op = 4'($urandom_range(9, 15));
                pos = $urandom_range(0, model_len + 2);
                if ($urandom_range(0, 20) == 0)
                    pos = $urandom_range(0, 13'h1FFF);
                pending_cmds.push_back(rand_cmd(op, pos, $urandom_range(0, 6)));
                if ($urandom_range(0, 20) == 0)
                    pending_cmds[$].line_index = 13'($urandom);
                if (op == OP_CLEAR)
                    model_len = 0;
                else if (op == OP_ERASE && pos < model_len)
                begin
                    if (pending_cmds[$].erase_length > model_len - pos)
                        model_len = pos;
                    else
                        model_len -= pending_cmds[$].erase_length;
                end
            end
        end

        wait (pending_cmds.size() == 0 && !cmd_valid);
        wait (expected_rsps.size() == 0);
        repeat (CAP + 50) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ram.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gbts_datapath.sv
hw/rtl/gap_buffer_text_store.sv
hw/rtl/gbts_checker.sv
tb/tb_gap_buffer_text_store.sv
